// File: src/deadline_release_queue_unit_macros.svh
// assertion macros for the deadline release queue
`ifndef DEADLINE_RELEASE_QUEUE_UNIT_MACROS_SVH
`define DEADLINE_RELEASE_QUEUE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define DRQ_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deadline release queue check failed");

// next-cycle implication, sampled on clk, off during reset
`define DRQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deadline release queue check failed");

`endif

// File: src/drq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// drq_pkg
// shared constants, types and helpers of the deadline release queue
// ---------------------------------------------------------------------------
package drq_pkg;

	localparam int CAPACITY     = 16;
	localparam int PAYLOAD_BITS = 32;
	localparam int MAX_RESULTS  = 16;
	localparam int AW           = $clog2(CAPACITY);
	localparam int CW           = $clog2(CAPACITY + 1);
	localparam int NW           = $clog2(MAX_RESULTS + 1);

	localparam logic KIND_SCHEDULE = 1'b0;
	localparam logic KIND_TICK     = 1'b1;

	localparam logic [1:0] ST_ACCEPTED = 2'd0;
	localparam logic [1:0] ST_REJECTED = 2'd1;
	localparam logic [1:0] ST_RELEASED = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_INS_PUT,
		S_REL_RD,
		S_REL_CMP,
		S_REL_FLUSH
	} state_t;

	typedef struct packed {
		logic [31:0]             deadline;
		logic [PAYLOAD_BITS-1:0] payload;
	} entry_t;

	// deadline d strictly after reference r, by signed difference
	function automatic logic is_after(input logic [31:0] d, input logic [31:0] r);
		logic [31:0] diff;
		diff = d - r;
		return (diff != 32'd0) && !diff[31];
	endfunction

	// physical slot of logical offset k from the head
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
			input logic [AW-1:0] k);
		logic [AW:0] sum;
		sum = {1'b0, head} + {1'b0, k};
		if (sum >= (AW+1)'(CAPACITY)) begin
			sum = sum - (AW+1)'(CAPACITY);
		end
		return sum[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
		logic [AW-1:0] res;
		if (idx == AW'(CAPACITY - 1)) begin
			res = '0;
		end else begin
			res = idx + AW'(1);
		end
		return res;
	endfunction

endpackage

// File: src/deadline_release_queue_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// deadline_release_queue_unit
// timed release queue: schedule payloads after a delay, release on ticks
// ---------------------------------------------------------------------------
// Usage:
//   An item is taken on a clock edge with start high and busy low. kind 0
//   schedules payload at deadline now + delay; kind 1 advances time by one
//   tick and releases every due entry, earliest deadline first, in order of
//   scheduling among equal deadlines.
//   Results come out one per strobe cycle with status, released_payload and
//   last; the last result of an item has last set. A tick with nothing due
//   gives no result.
// Timing:
//   A rejected schedule (queue full) shows its result the cycle after the
//   transfer and leaves busy low. An accepted schedule into an empty queue is
//   written directly; otherwise each later entry is read and moved back a
//   slot before the new one is written, using the one read and one write port
//   of the entry RAM. A tick reads and checks entries from the head in turn.
// Reset:
//   arst_n clears time, count and control; the entry RAM is not cleared,
//   only slots holding live entries are ever read.
// The receiver cannot stall: each result is valid for one cycle only.
// ---------------------------------------------------------------------------
module deadline_release_queue_unit
	import drq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [19:0] delay,
	input  logic [31:0] payload,
	output logic        strobe,
	output logic [1:0]  status,
	output logic [31:0] released_payload,
	output logic        last
);

	state_t                  state_q, state_d;
	logic [31:0]             now_q, now_d;
	logic [AW-1:0]           head_q, head_d;
	logic [CW-1:0]           count_q, count_d;
	logic [AW-1:0]           k_q, k_d;
	logic [NW-1:0]           n_q, n_d;
	logic                    pend_q, pend_d;
	logic [PAYLOAD_BITS-1:0] pend_pl_q, pend_pl_d;
	logic [31:0]             new_dl_q, new_dl_d;
	logic [PAYLOAD_BITS-1:0] new_pl_q, new_pl_d;

	entry_t                  entry_mem_q [CAPACITY];
	entry_t                  rd_data_q;
	logic                    mem_re, mem_we;
	logic [AW-1:0]           mem_raddr, mem_waddr;
	entry_t                  mem_wdata;

	logic                    res_valid, res_last;
	logic [1:0]              res_status;
	logic [31:0]             res_pl;

	logic                    strobe_q;
	logic [1:0]              status_q;
	logic [31:0]             rel_pl_q;
	logic                    last_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= entry_mem_q[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			now_q    <= '0;
			head_q   <= '0;
			count_q  <= '0;
			k_q      <= '0;
			n_q      <= '0;
			pend_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			now_q    <= now_d;
			head_q   <= head_d;
			count_q  <= count_d;
			k_q      <= k_d;
			n_q      <= n_d;
			pend_q   <= pend_d;
			strobe_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		pend_pl_q <= pend_pl_d;
		new_dl_q  <= new_dl_d;
		new_pl_q  <= new_pl_d;
		status_q  <= res_status;
		rel_pl_q  <= res_pl;
		last_q    <= res_last;
	end

	always_comb begin
		state_d    = state_q;
		now_d      = now_q;
		head_d     = head_q;
		count_d    = count_q;
		k_d        = k_q;
		n_d        = n_q;
		pend_d     = pend_q;
		pend_pl_d  = pend_pl_q;
		new_dl_d   = new_dl_q;
		new_pl_d   = new_pl_q;
		mem_re     = 1'b0;
		mem_raddr  = phys(head_q, k_q);
		mem_we     = 1'b0;
		mem_waddr  = phys(head_q, k_q + AW'(1));
		mem_wdata  = '{deadline: new_dl_q, payload: new_pl_q};
		res_valid  = 1'b0;
		res_status = ST_ACCEPTED;
		res_pl     = '0;
		res_last   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (kind == KIND_SCHEDULE) begin
						if (count_q == CW'(CAPACITY)) begin
							res_valid  = 1'b1;
							res_status = ST_REJECTED;
						end else begin
							new_dl_d = now_q + 32'(delay);
							new_pl_d = PAYLOAD_BITS'(payload);
							if (count_q == '0) begin
								k_d     = '0;
								state_d = S_INS_PUT;
							end else begin
								k_d     = AW'(count_q - CW'(1));
								state_d = S_INS_RD;
							end
						end
					end else begin
						now_d = now_q + 32'd1;
						if (count_q != '0) begin
							n_d     = '0;
							pend_d  = 1'b0;
							state_d = S_REL_RD;
						end
					end
				end
			end
			S_INS_RD: begin
				mem_re  = 1'b1;
				state_d = S_INS_CMP;
			end
			S_INS_CMP: begin
				mem_we = 1'b1;
				if (is_after(rd_data_q.deadline, new_dl_q)) begin
					// later entry moves back one slot
					mem_wdata = rd_data_q;
					if (k_q == '0) begin
						state_d = S_INS_PUT;
					end else begin
						k_d     = k_q - AW'(1);
						state_d = S_INS_RD;
					end
				end else begin
					count_d   = count_q + CW'(1);
					res_valid = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_INS_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = phys(head_q, k_q);
				count_d   = count_q + CW'(1);
				res_valid = 1'b1;
				state_d   = S_IDLE;
			end
			S_REL_RD: begin
				mem_re    = 1'b1;
				mem_raddr = head_q;
				state_d   = S_REL_CMP;
			end
			S_REL_CMP: begin
				// a release is held back one step to learn whether it is the last
				if (!is_after(rd_data_q.deadline, now_q)) begin
					if (pend_q) begin
						res_valid  = 1'b1;
						res_status = ST_RELEASED;
						res_pl     = 32'(pend_pl_q);
						res_last   = 1'b0;
					end
					pend_d    = 1'b1;
					pend_pl_d = rd_data_q.payload;
					head_d    = wrap_inc(head_q);
					count_d   = count_q - CW'(1);
					n_d       = n_q + NW'(1);
					if (count_q == CW'(1) || n_q == NW'(MAX_RESULTS - 1)) begin
						state_d = S_REL_FLUSH;
					end else begin
						state_d = S_REL_RD;
					end
				end else begin
					if (pend_q) begin
						res_valid  = 1'b1;
						res_status = ST_RELEASED;
						res_pl     = 32'(pend_pl_q);
					end
					pend_d  = 1'b0;
					state_d = S_IDLE;
				end
			end
			S_REL_FLUSH: begin
				res_valid  = 1'b1;
				res_status = ST_RELEASED;
				res_pl     = 32'(pend_pl_q);
				pend_d     = 1'b0;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy             = (state_q != S_IDLE);
	assign strobe           = strobe_q;
	assign status           = status_q;
	assign released_payload = rel_pl_q;
	assign last             = last_q;

endmodule

// File: src/drq_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// drq_checker
// port-level checks of the deadline release queue, bound to the top level
// ---------------------------------------------------------------------------
`include "deadline_release_queue_unit_macros.svh"

module drq_checker
	import drq_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        strobe,
	input logic [1:0]  status,
	input logic [31:0] released_payload,
	input logic        last
);

	// only defined status codes reach the port
	`DRQ_ASSERT_SAME(a_status_code, strobe, status == ST_ACCEPTED || status == ST_REJECTED || status == ST_RELEASED)

	// a schedule answer is a single result
	`DRQ_ASSERT_SAME(a_sched_last, strobe && status != ST_RELEASED, last)

	// no payload on schedule answers
	`DRQ_ASSERT_SAME(a_sched_zero, strobe && status != ST_RELEASED, released_payload == 32'd0)

	// a release that is not the last is directly followed by nothing or another release
	`DRQ_ASSERT_NEXT(a_rel_follow, strobe && status == ST_RELEASED && !last, !strobe || status == ST_RELEASED)

endmodule

bind deadline_release_queue_unit drq_checker u_drq_checker (.*);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for deadline_release_queue_unit: a queue-fed driver
// offers schedule and tick commands in random bursts, and a clocked monitor
// compares every result strobe with a timed release queue kept in the bench
// ---------------------------------------------------------------------------
module testbench;
	import drq_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int TAIL_CYCLES = 60;

	typedef struct packed {
		logic        kind;
		logic [19:0] delay;
		logic [31:0] payload;
		logic        hold;
	} command_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] payload;
		logic        last;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        kind = KIND_SCHEDULE;
	logic [19:0] delay = '0;
	logic [31:0] payload = '0;
	logic        busy;
	logic        strobe;
	logic [1:0]  status;
	logic [31:0] released_payload;
	logic        last;

	command_t command_queue[$];
	outcome_t expected_outcomes[$];
	command_t sent_command;
	outcome_t oldest_outcome;
	logic     took = 1'b0;
	int       error_count = 0;
	int       quiet_cycles = 0;
	int       burst_left = 4;
	int       gap_left = 0;
	int       item_total = 0;

	logic [31:0] model_now = '0;
	logic [31:0] model_deadline [CAPACITY];
	logic [31:0] model_payload [CAPACITY];
	int          model_count = 0;

	deadline_release_queue_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.kind             (kind),
		.delay            (delay),
		.payload          (payload),
		.strobe           (strobe),
		.status           (status),
		.released_payload (released_payload),
		.last             (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// true when deadline d lies strictly after point r on the wrapping clock
	function automatic logic deadline_later(input logic [31:0] d, input logic [31:0] r);
		logic signed [31:0] ahead;
		ahead = d - r;
		return ahead > 0;
	endfunction

	function automatic void step_queue_model(input command_t c);
		logic [31:0] due_at;
		outcome_t    o;
		int          pos;
		int          due;
		if (c.kind == KIND_SCHEDULE) begin
			o.payload = '0;
			o.last = 1'b1;
			if (model_count >= CAPACITY) begin
				o.status = ST_REJECTED;
			end else begin
				due_at = model_now + 32'(c.delay);
				pos = 0;
				while (pos < model_count && !deadline_later(model_deadline[pos], due_at)) begin
					pos++;
				end
				for (int i = model_count; i > pos; i--) begin
					model_deadline[i] = model_deadline[i - 1];
					model_payload[i] = model_payload[i - 1];
				end
				model_deadline[pos] = due_at;
				model_payload[pos] = c.payload;
				model_count++;
				o.status = ST_ACCEPTED;
			end
			expected_outcomes.push_back(o);
		end else begin
			model_now = model_now + 32'd1;
			due = 0;
			while (due < model_count && due < MAX_RESULTS &&
					!deadline_later(model_deadline[due], model_now)) begin
				due++;
			end
			for (int i = 0; i < due; i++) begin
				o.status = ST_RELEASED;
				o.payload = model_payload[i];
				o.last = (i == due - 1);
				expected_outcomes.push_back(o);
			end
			for (int i = due; i < model_count; i++) begin
				model_deadline[i - due] = model_deadline[i];
				model_payload[i - due] = model_payload[i];
			end
			model_count = model_count - due;
		end
	endfunction

	function automatic void add_command(input logic k, input logic [19:0] d,
			input logic [31:0] p, input logic h);
		command_t c;
		c.kind = k;
		c.delay = d;
		c.payload = p;
		c.hold = h;
		command_queue.push_back(c);
		item_total++;
	endfunction

	// tick commands carry random filler in the unused fields
	function automatic void add_ticks(input int n);
		for (int i = 0; i < n; i++) begin
			add_command(KIND_TICK, 20'($urandom()), $urandom(), 1'b0);
		end
	endfunction

	always @(negedge clk) begin
		if (arst_n) begin
			if (took) begin
				sent_command = command_queue.pop_front();
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
				end
			end
			// an offered command stays up until its transfer
			if (!start || took) begin
				if (command_queue.size() == 0 || gap_left > 0 ||
						(command_queue[0].hold && (expected_outcomes.size() != 0 || busy))) begin
					start <= 1'b0;
					if (gap_left > 0) begin
						gap_left--;
					end
				end else begin
					start <= 1'b1;
					kind <= command_queue[0].kind;
					delay <= command_queue[0].delay;
					payload <= command_queue[0].payload;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			took <= 1'b0;
		end else begin
			took <= start && !busy;
			quiet_cycles <= (strobe || (start && !busy)) ? 0 : quiet_cycles + 1;
			if (strobe) begin
				if (expected_outcomes.size() == 0) begin
					$display("%0t: unexpected result: status %0d payload %h last %0b",
						$time, status, released_payload, last);
					error_count++;
				end else begin
					oldest_outcome = expected_outcomes.pop_front();
					if (status !== oldest_outcome.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, oldest_outcome.status, status);
						error_count++;
					end
					if (released_payload !== oldest_outcome.payload) begin
						$display("%0t: released_payload expected %h actual %h",
							$time, oldest_outcome.payload, released_payload);
						error_count++;
					end
					if (last !== oldest_outcome.last) begin
						$display("%0t: last expected %0b actual %0b",
							$time, oldest_outcome.last, last);
						error_count++;
					end
				end
			end
			if (start && !busy) begin
				step_queue_model({kind, delay, payload, 1'b0});
			end
		end
	end

	initial begin
		@(posedge arst_n);
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		int pick;
		int round;
		int far_left;
		int d;
		int n;
		int span;
		// empty tick, zero delay, extremes of payload, ties and inserts in the middle
		add_ticks(1);
		add_command(KIND_SCHEDULE, 20'd0, 32'h0000_0000, 1'b0);
		add_ticks(1);
		add_command(KIND_SCHEDULE, 20'd0, 32'hFFFF_FFFF, 1'b0);
		add_command(KIND_SCHEDULE, 20'd2, $urandom(), 1'b0);
		add_command(KIND_SCHEDULE, 20'd2, $urandom(), 1'b0);
		add_command(KIND_SCHEDULE, 20'd1, $urandom(), 1'b0);
		add_command(KIND_SCHEDULE, 20'd0, $urandom(), 1'b0);
		add_ticks(3);
		add_command(KIND_SCHEDULE, 20'd5, $urandom(), 1'b0);
		add_command(KIND_SCHEDULE, 20'd3, $urandom(), 1'b0);
		add_command(KIND_SCHEDULE, 20'd4, $urandom(), 1'b0);
		add_command(KIND_SCHEDULE, 20'd0, $urandom(), 1'b0);
		add_ticks(6);

		round = 0;
		far_left = 2;
		while (item_total < 380) begin
			pick = (round == 0) ? 0 : $urandom_range(0, 99);
			if (pick < 12) begin
				// overfill with one shared deadline, then tick past it
				d = $urandom_range(0, 3);
				for (int i = 0; i < CAPACITY + 2; i++) begin
					add_command(KIND_SCHEDULE, 20'(d), $urandom(),
						(i == 0) && (round == 0 || pick < 4));
				end
				add_ticks(d + 2);
				if (round == 0) begin
					add_command(KIND_SCHEDULE, 20'hFFFFF, $urandom(), 1'b0);
				end
			end else if (pick < 24) begin
				for (int i = 0; i < 8; i++) begin
					if ($urandom_range(0, 1) == 0) begin
						add_ticks(1);
					end else if (far_left > 0 && $urandom_range(0, 5) == 0) begin
						add_command(KIND_SCHEDULE, 20'($urandom()), $urandom(), 1'b0);
						far_left--;
					end else begin
						add_command(KIND_SCHEDULE, 20'($urandom_range(0, 40)), $urandom(), 1'b0);
					end
				end
			end else begin
				n = $urandom_range(1, 6);
				span = ($urandom_range(0, 3) == 0) ? 15 : 6;
				for (int i = 0; i < n; i++) begin
					add_command(KIND_SCHEDULE, 20'($urandom_range(0, span)), $urandom(), 1'b0);
				end
				add_ticks($urandom_range(1, 8));
			end
			round++;
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (command_queue.size() != 0 || start) begin
			@(posedge clk);
		end
		while (expected_outcomes.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_outcomes.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// File: deadline_release_queue_unit.f
+incdir+src
src/drq_pkg.sv
src/deadline_release_queue_unit.sv
src/drq_checker.sv
tb/sv/testbench.sv
